### sv/gqdp_pkg.sv
// Shared types and constants for the group quantised dot product block.
package gqdp_pkg;

  localparam int MAX_GROUP_DEF = 256;
  localparam int GL_W          = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 9;
  localparam int RES_W         = 48;
  localparam int ACC_W         = 64;
  localparam int WSUM_W        = 32;
  localparam int ASUM_W        = 24;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE  = 1'b1;

  localparam logic [GL_W-1:0] GROUP_LENGTH_RST = 9'd32;

  typedef struct packed {
    logic signed [15:0] act_value;
    logic        [7:0]  weight_index;
    logic signed [15:0] group_scale;
    logic signed [15:0] group_offset;
    logic signed [15:0] bias_value;
    logic               row_last;
  } gqdp_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] dot_result;
    logic                    saturated;
  } gqdp_out_t;

  typedef struct packed {
    logic capture;
    logic mac;
    logic mul;
    logic acc;
    logic fin;
  } gqdp_cmd_t;

  typedef struct packed {
    logic group_end;
    logic row_last;
  } gqdp_sts_t;

endpackage

### sv/group_quantized_dot_product.sv
// Group quantised dot product: one output element per row of activation and weight-code words.
// Each input word is accepted in the idle state and then passes through MAC; a word that closes a
// group goes on through the scale and offset multiplies and the saturating accumulate, and a
// row-last word through the final state, which adds the bias if enabled and loads the result
// register. The result register parts the two sides, so the next word is accepted while a result
// waits; a row end stalls only while an earlier result is still untaken. Results are Q21.26,
// saturated to 48 bits; a partial group at row end is dropped.
module group_quantized_dot_product #(
  parameter int MAX_GROUP = gqdp_pkg::MAX_GROUP_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gqdp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gqdp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gqdp_pkg::gqdp_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gqdp_pkg::gqdp_out_t             out_data
);
  import gqdp_pkg::*;

  gqdp_cmd_t cmd;
  gqdp_sts_t sts;

  gqdp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gqdp_dp #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

### sv/gqdp_ctrl.sv
// Sequencer for the group quantised dot product: steps each word through MAC, group end and row end.
module gqdp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  gqdp_pkg::gqdp_sts_t sts,
  output gqdp_pkg::gqdp_cmd_t cmd
);
  import gqdp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_MUL,
    S_ACC,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    cmd.capture = (state_r == S_IDLE) && in_valid;
    cmd.mac     = (state_r == S_MAC);
    cmd.mul     = (state_r == S_MUL);
    cmd.acc     = (state_r == S_ACC);
    cmd.fin     = (state_r == S_FIN) && out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_MAC;
      end
      S_MAC: begin
        if (sts.group_end)     state_nxt = S_MUL;
        else if (sts.row_last) state_nxt = S_FIN;
        else                   state_nxt = S_IDLE;
      end
      S_MUL: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = sts.row_last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/gqdp_dp.sv
// Datapath for the group quantised dot product: group sums, group-end products, row accumulator.
module gqdp_dp #(
  parameter int MAX_GROUP = gqdp_pkg::MAX_GROUP_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gqdp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gqdp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  gqdp_pkg::gqdp_in_t              in_data,
  input  gqdp_pkg::gqdp_cmd_t             cmd,
  output gqdp_pkg::gqdp_sts_t             sts,
  output gqdp_pkg::gqdp_out_t             out_data
);
  import gqdp_pkg::*;

  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int CMP_W = (CNT_W > GL_W) ? CNT_W : GL_W;

  logic [GL_W-1:0]          group_length_r;
  logic                     bias_enable_r;
  gqdp_in_t                 in_r;
  logic signed [WSUM_W-1:0] ws_r, ws_nxt;
  logic signed [ASUM_W-1:0] as_r, as_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [47:0]       p1_r;
  logic signed [39:0]       p2_r;
  logic [ACC_W-1:0]         acc_r;
  gqdp_out_t                out_r;

  logic signed [24:0]       prod;
  logic [CMP_W-1:0]         gl_ext, eff_len, cnt_inc;
  logic [48:0]              contrib;
  logic [ACC_W-1:0]         acc_sum, bias_ext, res;
  logic                     in_range;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

  always_comb begin
    gl_ext = CMP_W'(group_length_r);
    if (group_length_r == '0)                 eff_len = CMP_W'(1);
    else if (gl_ext > CMP_W'(MAX_GROUP))      eff_len = CMP_W'(MAX_GROUP);
    else                                      eff_len = gl_ext;
  end

  assign prod    = in_r.act_value * $signed({1'b0, in_r.weight_index});
  assign ws_nxt  = ws_r + {{(WSUM_W-25){prod[24]}}, prod};
  assign as_nxt  = as_r + {{(ASUM_W-16){in_r.act_value[15]}}, in_r.act_value};
  assign cnt_nxt = cnt_r + 1'b1;
  assign cnt_inc = CMP_W'(cnt_nxt);

  assign sts.group_end = (cnt_inc >= eff_len);
  assign sts.row_last  = in_r.row_last;

  assign contrib  = {p1_r[47], p1_r} + {{9{p2_r[39]}}, p2_r};
  assign bias_ext = {{(ACC_W-30){in_r.bias_value[15]}}, in_r.bias_value, 14'b0};
  assign acc_sum  = sat_add(acc_r, {{(ACC_W-49){contrib[48]}}, contrib});
  assign res      = bias_enable_r ? sat_add(acc_r, bias_ext) : acc_r;
  assign in_range = (&res[ACC_W-1:RES_W-1]) || !(|res[ACC_W-1:RES_W-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_length_r <= GROUP_LENGTH_RST;
      bias_enable_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GROUP_LENGTH: group_length_r <= cfg_data;
        REG_BIAS_ENABLE:  bias_enable_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r  <= '0;
      as_r  <= '0;
      cnt_r <= '0;
      acc_r <= '0;
    end else begin
      if (cmd.mac && !sts.group_end) begin
        ws_r  <= ws_nxt;
        as_r  <= as_nxt;
        cnt_r <= cnt_nxt;
      end else if (cmd.mac) begin
        ws_r <= ws_nxt;
        as_r <= as_nxt;
      end
      if (cmd.mul || cmd.fin) begin
        ws_r  <= '0;
        as_r  <= '0;
        cnt_r <= '0;
      end
      if (cmd.acc) acc_r <= acc_sum;
      if (cmd.fin) acc_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    if (cmd.mul) begin
      p1_r <= in_r.group_scale * ws_r;
      p2_r <= in_r.group_offset * as_r;
    end
    if (cmd.fin) begin
      out_r.saturated <= !in_range;
      if (in_range)          out_r.dot_result <= res[RES_W-1:0];
      else if (res[ACC_W-1]) out_r.dot_result <= {1'b1, {(RES_W-1){1'b0}}};
      else                   out_r.dot_result <= {1'b0, {(RES_W-1){1'b1}}};
    end
  end

  assign out_data = out_r;

endmodule
